### hw/rtl/sloa_pkg.sv
// Package for the slab object allocator: sizes, metadata record, state codes
// and size-class helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sloa_pkg;

    localparam int NUM_PAGES    = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 32;
    localparam int NUM_CLASSES  = 8;

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int SLOT_W  = 8;
    localparam int CLS_W   = 3;
    localparam int ADDR_W  = 18;
    localparam int SIZE_W  = 16;
    localparam int STAMP_W = 32;
    localparam int LINK_DEPTH = NUM_PAGES * (1 << SLOT_W);
    localparam int MAX_CLASS_BYTES = 16 << (NUM_CLASSES - 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_PAGE   = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [CLS_W-1:0]   cls;
        logic [SLOT_W-1:0]  live;
        logic [SLOT_W-1:0]  head;
        logic [STAMP_W-1:0] stamp;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_LINKW,
        S_BUILD,
        S_FREE_RD,
        S_FREE_CHK,
        S_OUT
    } t_state;

    function automatic logic [OFF_W:0] class_bytes(input logic [CLS_W-1:0] c);
        class_bytes = (OFF_W+1)'(16) << c;
    endfunction

    // smallest class that holds the request, zero counts as one
    function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] req);
        logic [CLS_W-1:0] c;
        logic [SIZE_W-1:0] r;
        c = CLS_W'(NUM_CLASSES - 1);
        r = (req == '0) ? SIZE_W'(1) : req;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (r <= SIZE_W'(16 << k)) c = CLS_W'(k);
        end
        size_class = c;
    endfunction

    function automatic logic too_large(input logic [SIZE_W-1:0] req);
        too_large = (req > SIZE_W'(MAX_CLASS_BYTES));
    endfunction

    function automatic logic [OFF_W:0] first_offset(input logic [CLS_W-1:0] c);
        logic [OFF_W:0] sz;
        sz = class_bytes(c);
        first_offset = ((OFF_W+1)'(HEADER_BYTES) + sz - 1'b1) & ~(sz - 1'b1);
    endfunction

    function automatic logic [SLOT_W-1:0] first_slot(input logic [CLS_W-1:0] c);
        logic [OFF_W:0] o;
        o = first_offset(c) >> ({1'b0, c} + 4'd4);
        first_slot = o[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] last_slot(input logic [CLS_W-1:0] c);
        logic [OFF_W:0] n;
        n = ((OFF_W+1)'(PAGE_BYTES) >> ({1'b0, c} + 4'd4)) - 1'b1;
        last_slot = (n > (OFF_W+1)'((1 << SLOT_W) - 1)) ? '1 : n[SLOT_W-1:0];
    endfunction

    function automatic logic [OFF_W-1:0] slot_offset(input logic [SLOT_W-1:0] s,
                                                     input logic [CLS_W-1:0] c);
        logic [OFF_W+SLOT_W-1:0] o;
        o = {{OFF_W{1'b0}}, s} << ({1'b0, c} + 4'd4);
        slot_offset = o[OFF_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/slab_object_allocator_unit.sv
// Slab object allocator top level: sequencer over page metadata and slot link RAMs.
// Depends on sloa_pkg and sloa_ram.
//
// Usage: one request channel (i_in_valid/o_in_ready) carries an operation:
// allocate with i_request_size, or free with i_free_address. Each request gives
// one result on the output channel (o_out_valid/i_out_ready): address, status,
// page-released flag. One request is worked on at a time.
// Sequence: a too-large allocate goes straight to the result; a free reads the page
// metadata, checks it and, if valid, writes metadata and slot link back; an allocate
// from an existing slab scans the metadata, one cycle per page through the metadata
// RAM read port, then reads the link and writes back; a new slab, after the scan, gets
// its slot chain (up to 254 slots) written one link per cycle via the link RAM port.
// Reset clears the page-in-use bits, the stamp counter and the control state;
// the RAMs need no clearing since read data is only used for entries already written.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and worked on, and waits to deliver until the output frees.
`timescale 1ns / 1ps
`default_nettype none
module slab_object_allocator_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_operation,
    input  wire logic [sloa_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic [sloa_pkg::ADDR_W-1:0] i_free_address,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [sloa_pkg::ADDR_W-1:0] o_object_address,
    output logic      [1:0]                  o_status,
    output logic                             o_page_released
);
    import sloa_pkg::*;

    t_state r_state, n_state;
    logic [CLS_W-1:0]   r_cls, n_cls;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [PAGE_W:0]    r_scan_p, n_scan_p;
    logic               r_scan_vld, n_scan_vld;
    logic [PAGE_W-1:0]  r_scan_pd, n_scan_pd;
    logic               r_found, n_found;
    logic [PAGE_W-1:0]  r_best, n_best;
    logic [STAMP_W-1:0] r_best_age, n_best_age;
    t_meta              r_best_meta, n_best_meta;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [STAMP_W-1:0] r_stamp_ctr, n_stamp_ctr;
    logic [NUM_PAGES-1:0] r_in_use, n_in_use;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic [1:0]         r_res_status, n_res_status;
    logic               r_res_rel, n_res_rel;
    logic               r_o_valid, n_o_valid;
    logic [ADDR_W-1:0]  r_o_addr, n_o_addr;
    logic [1:0]         r_o_status, n_o_status;
    logic               r_o_rel, n_o_rel;

    logic                meta_we;
    logic [PAGE_W-1:0]   meta_waddr, meta_raddr;
    t_meta               meta_wdata, meta_rdata;
    logic                link_we;
    logic [PAGE_W+SLOT_W-1:0] link_waddr, link_raddr;
    logic [SLOT_W-1:0]   link_wdata, link_rdata;

    sloa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    sloa_ram #(.WIDTH(SLOT_W), .DEPTH(LINK_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // lowest free page
    logic              free_any;
    logic [PAGE_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = NUM_PAGES - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                free_any = 1'b1;
                free_idx = PAGE_W'(k);
            end
        end
    end

    logic [STAMP_W-1:0] scan_age;
    logic               scan_hit;
    logic [PAGE_W-1:0]  f_page;
    logic [OFF_W-1:0]   f_off;
    logic [OFF_W:0]     f_size;
    logic [OFF_W+SLOT_W-1:0] f_slot_w;
    logic [SLOT_W-1:0]  f_slot;
    logic               f_ok;
    logic [SLOT_W-1:0]  f_live_dec;
    logic [CLS_W-1:0]   c_req;

    assign c_req    = size_class(i_request_size);
    assign scan_age = r_stamp_ctr - meta_rdata.stamp;
    assign scan_hit = r_in_use[r_scan_pd] && (meta_rdata.cls == r_cls)
                      && (meta_rdata.head != '0);
    assign f_page   = r_addr[ADDR_W-1:OFF_W];
    assign f_off    = r_addr[OFF_W-1:0];
    assign f_size   = class_bytes(meta_rdata.cls);
    assign f_slot_w = {{SLOT_W{1'b0}}, f_off} >> ({1'b0, meta_rdata.cls} + 4'd4);
    assign f_slot   = f_slot_w[SLOT_W-1:0];
    assign f_live_dec = meta_rdata.live - 1'b1;
    assign f_ok = r_in_use[f_page] && (meta_rdata.live != '0)
                  && ((f_off & OFF_W'(f_size - 1'b1)) == '0)
                  && ({1'b0, f_off} >= first_offset(meta_rdata.cls))
                  && (({1'b0, f_off} + f_size) <= (OFF_W+1)'(PAGE_BYTES));

    always_comb begin
        n_state      = r_state;
        n_cls        = r_cls;
        n_addr       = r_addr;
        n_scan_p     = r_scan_p;
        n_scan_vld   = 1'b0;
        n_scan_pd    = r_scan_pd;
        n_found      = r_found;
        n_best       = r_best;
        n_best_age   = r_best_age;
        n_best_meta  = r_best_meta;
        n_slot       = r_slot;
        n_stamp_ctr  = r_stamp_ctr;
        n_in_use     = r_in_use;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_rel    = r_res_rel;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_addr     = r_o_addr;
        n_o_status   = r_o_status;
        n_o_rel      = r_o_rel;
        o_in_ready   = (r_state == S_IDLE);
        meta_we      = 1'b0;
        meta_waddr   = r_best;
        meta_wdata   = r_best_meta;
        meta_raddr   = (r_state == S_SCAN) ? r_scan_p[PAGE_W-1:0] : f_page;
        link_we      = 1'b0;
        link_waddr   = {r_best, r_slot};
        link_wdata   = '0;
        link_raddr   = {r_best, r_best_meta.head};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_addr       = i_free_address;
                    n_cls        = c_req;
                    n_res_addr   = '0;
                    n_res_status = ST_OK;
                    n_res_rel    = 1'b0;
                    n_scan_p     = '0;
                    n_found      = 1'b0;
                    if (i_operation == OP_FREE) begin
                        n_state = S_FREE_RD;
                    end else if (too_large(i_request_size)) begin
                        n_res_status = ST_TOO_LARGE;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan_p != (PAGE_W+1)'(NUM_PAGES)) begin
                    n_scan_vld = 1'b1;
                    n_scan_pd  = r_scan_p[PAGE_W-1:0];
                    n_scan_p   = r_scan_p + 1'b1;
                end
                if (r_scan_vld && scan_hit && (!r_found || scan_age > r_best_age)) begin
                    n_found     = 1'b1;
                    n_best      = r_scan_pd;
                    n_best_age  = scan_age;
                    n_best_meta = meta_rdata;
                end
                if (r_scan_p == (PAGE_W+1)'(NUM_PAGES) && !r_scan_vld) begin
                    if (r_found) begin
                        n_state = S_LINK;
                    end else if (!free_any) begin
                        n_res_status = ST_NO_PAGE;
                        n_state      = S_OUT;
                    end else begin
                        n_best  = free_idx;
                        n_slot  = first_slot(r_cls);
                        n_state = S_BUILD;
                    end
                end
            end
            S_LINK: begin
                n_state = S_LINKW;
            end
            S_LINKW: begin
                meta_we         = 1'b1;
                meta_wdata.head = link_rdata;
                meta_wdata.live = r_best_meta.live + 1'b1;
                n_res_addr      = {r_best, slot_offset(r_best_meta.head, r_cls)};
                n_state         = S_OUT;
            end
            S_BUILD: begin
                // chain grows upward: each slot links to the one below it
                link_we    = 1'b1;
                link_wdata = (r_slot == first_slot(r_cls)) ? '0 : r_slot - 1'b1;
                if (r_slot == last_slot(r_cls)) begin
                    meta_we          = 1'b1;
                    meta_wdata.cls   = r_cls;
                    meta_wdata.live  = SLOT_W'(1);
                    meta_wdata.head  = link_wdata;
                    meta_wdata.stamp = r_stamp_ctr;
                    n_stamp_ctr      = r_stamp_ctr + 1'b1;
                    n_in_use[r_best] = 1'b1;
                    n_res_addr       = {r_best, slot_offset(r_slot, r_cls)};
                    n_state          = S_OUT;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                meta_waddr = f_page;
                meta_wdata = meta_rdata;
                link_waddr = {f_page, f_slot};
                link_wdata = meta_rdata.head;
                if (f_ok) begin
                    meta_we         = 1'b1;
                    link_we         = 1'b1;
                    meta_wdata.live = f_live_dec;
                    meta_wdata.head = f_slot;
                    if (f_live_dec == '0) begin
                        meta_wdata.head  = '0;
                        n_in_use[f_page] = 1'b0;
                        n_res_rel        = 1'b1;
                    end
                end else begin
                    n_res_status = ST_REFUSED;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_addr   = r_res_addr;
                    n_o_status = r_res_status;
                    n_o_rel    = r_res_rel;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_vld  <= 1'b0;
            r_stamp_ctr <= '0;
            r_in_use    <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_vld  <= n_scan_vld;
            r_stamp_ctr <= n_stamp_ctr;
            r_in_use    <= n_in_use;
            r_o_valid   <= n_o_valid;
        end
        r_cls        <= n_cls;
        r_addr       <= n_addr;
        r_scan_p     <= n_scan_p;
        r_scan_pd    <= n_scan_pd;
        r_found      <= n_found;
        r_best       <= n_best;
        r_best_age   <= n_best_age;
        r_best_meta  <= n_best_meta;
        r_slot       <= n_slot;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_rel    <= n_res_rel;
        r_o_addr     <= n_o_addr;
        r_o_status   <= n_o_status;
        r_o_rel      <= n_o_rel;
    end

    assign o_out_valid      = r_o_valid;
    assign o_object_address = r_o_addr;
    assign o_status         = r_o_status;
    assign o_page_released  = r_o_rel;
endmodule
`default_nettype wire

### hw/rtl/sloa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sloa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
